FILE: rtl/core/plmr_pkg.sv
// Shared types and constants for the packet loss map reporter.
// No dependencies; every other file in rtl/core imports this package.
package plmr_pkg;

   localparam int MAX_PACKETS_DEF = 64;

   localparam int PKT_W      = 7;   // packet numbers and packet counts
   localparam int GRP_W      = 6;   // run counts
   localparam int SEQ_W      = 8;
   localparam int TYPE_W     = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [PKT_W-1:0] TOTAL_RESET = 7'd64;

   // request types
   localparam logic [TYPE_W-1:0] REQ_ARRIVE = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_REPORT = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_CLEAR  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 1'b1;

   // result kinds
   localparam logic KIND_ACK   = 1'b0;
   localparam logic KIND_ENTRY = 1'b1;

   typedef struct packed {
      logic [TYPE_W-1:0] req_type;
      logic [SEQ_W-1:0]  seq_number;
   } req_word_type;

   typedef struct packed {
      logic             result_kind;
      logic             accepted;
      logic             is_final_packet;
      logic             entry_valid;
      logic [PKT_W-1:0] entry_value;
      logic [PKT_W-1:0] missing_packets;
      logic [GRP_W-1:0] missing_groups;
      logic             end_of_run;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic arrive;
      logic clear;
      logic report_empty;
      logic scan_start;
      logic scan_step;
      logic recount_start;
      logic recount_step;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
      logic pk_zero;
      logic scan_last;
      logic recount_last;
   } status_type;

endpackage

FILE: rtl/core/plmr_ctrl.sv
// Controller FSM: request dispatch, report scan and recount sequencing.
// Depends on plmr_pkg.
module plmr_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [plmr_pkg::TYPE_W-1:0]    req_type,
   input  logic                           csr_we,
   input  logic [plmr_pkg::CSR_IDX_W-1:0] csr_index,
   input  plmr_pkg::status_type           status,
   output plmr_pkg::cmd_type              cmd
);
   import plmr_pkg::*;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_RECOUNT = 2'd1;
   localparam logic [1:0] ST_SCAN    = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       take;

   assign req_ready = (state_ff == ST_IDLE) && status.out_free && !csr_we;
   assign take      = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_we && csr_index == CSR_TOTAL) begin
               cmd.recount_start = 1'b1;
               state_in          = ST_RECOUNT;
            end else if (take) begin
               case (req_type)
                  REQ_ARRIVE: cmd.arrive = 1'b1;
                  REQ_CLEAR:  cmd.clear  = 1'b1;
                  REQ_REPORT: begin
                     if (status.pk_zero) begin
                        cmd.report_empty = 1'b1;
                     end else begin
                        cmd.scan_start = 1'b1;
                        state_in       = ST_SCAN;
                     end
                  end
                  default: ;  // unused type, dropped
               endcase
            end
         end
         ST_RECOUNT: begin
            if (csr_we && csr_index == CSR_TOTAL) begin
               cmd.recount_start = 1'b1;   // new total: start over
            end else begin
               cmd.recount_step = 1'b1;
               if (status.recount_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            if (status.out_free) begin
               cmd.scan_step = 1'b1;
               if (status.scan_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/plmr_dpath.sv
// Datapath: config registers, received bitmap, running loss counts,
// scan pointer and the output word register. Depends on plmr_pkg.
module plmr_dpath #(
   parameter int MAX_PACKETS = plmr_pkg::MAX_PACKETS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  plmr_pkg::req_word_type          req_data,
   input  logic                            csr_we,
   input  logic [plmr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [plmr_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  plmr_pkg::cmd_type               cmd,
   output plmr_pkg::status_type            status,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output plmr_pkg::rsp_word_type          rsp_data
);
   import plmr_pkg::*;

   localparam int IDX_W = $clog2(MAX_PACKETS);
   localparam int XW    = $clog2(MAX_PACKETS + 2);
   localparam logic [PKT_W-1:0] MAX_P = PKT_W'(MAX_PACKETS);
   localparam logic [PKT_W-1:0] ONE_P = PKT_W'(1);
   localparam logic [GRP_W-1:0] ONE_G = GRP_W'(1);

   logic [PKT_W-1:0]       tot_ff, tot_in;
   logic                   mode_ff, mode_in;
   logic [MAX_PACKETS-1:0] map_ff, map_in;
   logic [PKT_W-1:0]       pk_ff, pk_in;
   logic [GRP_W-1:0]       gr_ff, gr_in;
   logic [PKT_W-1:0]       n_ff, n_in;
   logic [PKT_W-1:0]       cnt_ff, cnt_in;
   logic                   half_ff, half_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_ff, rsp_in;

   logic [PKT_W-1:0]       tot_eff;
   logic [MAX_PACKETS+1:0] ext;       // bit n = packet n received; ends read as received
   logic [PKT_W-1:0]       s, s_up, s_dn, n_up, n_dn, target;
   logic                   acc, fin, newly, left_miss, right_miss;
   logic                   miss, run_start, run_end, emit, advance, last;

   always_comb begin
      if (tot_ff == '0) begin
         tot_eff = ONE_P;
      end else if (tot_ff > MAX_P) begin
         tot_eff = MAX_P;
      end else begin
         tot_eff = tot_ff;
      end
   end

   assign ext = {1'b1, map_ff, 1'b1};

   // arrival
   assign s          = req_data.seq_number[PKT_W-1:0];
   assign s_up       = s + ONE_P;
   assign s_dn       = s - ONE_P;
   assign acc        = (req_data.seq_number != '0) &&
                       (req_data.seq_number <= {1'b0, tot_eff});
   assign fin        = acc && (s == tot_eff);
   assign newly      = acc && !ext[s[XW-1:0]];
   assign left_miss  = !ext[s_dn[XW-1:0]];
   assign right_miss = (s != tot_eff) && !ext[s_up[XW-1:0]];

   // scan / recount position
   assign n_up      = n_ff + ONE_P;
   assign n_dn      = n_ff - ONE_P;
   assign miss      = !ext[n_ff[XW-1:0]];
   assign run_start = miss && ext[n_dn[XW-1:0]];
   assign run_end   = miss && ((n_ff == tot_eff) || ext[n_up[XW-1:0]]);
   assign target    = mode_ff ? {gr_ff, 1'b0} : pk_ff;

   always_comb begin
      half_in = half_ff;
      if (!mode_ff) begin
         emit    = miss;
         advance = 1'b1;
      end else if (half_ff) begin
         emit    = 1'b1;
         advance = 1'b1;
         half_in = 1'b0;
      end else if (run_start && run_end) begin
         emit    = 1'b1;   // single-packet run: start now, end on the next scan step
         advance = 1'b0;
         half_in = 1'b1;
      end else begin
         emit    = run_start || run_end;
         advance = 1'b1;
      end
   end

   assign last = emit && ((cnt_ff + ONE_P) == target);

   always_comb begin
      tot_in       = tot_ff;
      mode_in      = mode_ff;
      map_in       = map_ff;
      pk_in        = pk_ff;
      gr_in        = gr_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_we) begin
         unique case (csr_index)
            CSR_TOTAL: tot_in  = csr_wdata[PKT_W-1:0];
            CSR_MODE:  mode_in = csr_wdata[0];
            default: ;
         endcase
      end

      if (cmd.arrive) begin
         if (newly) begin
            map_in[s_dn[IDX_W-1:0]] = 1'b1;
            pk_in                   = pk_ff - ONE_P;
            if (left_miss && right_miss) begin
               gr_in = gr_ff + ONE_G;      // run split in two
            end else if (!left_miss && !right_miss) begin
               gr_in = gr_ff - ONE_G;      // run of one vanished
            end
         end
         rsp_in.result_kind     = KIND_ACK;
         rsp_in.accepted        = acc;
         rsp_in.is_final_packet = fin;
         rsp_in.entry_valid     = 1'b0;
         rsp_in.entry_value     = '0;
         rsp_in.missing_packets = pk_in;
         rsp_in.missing_groups  = gr_in;
         rsp_in.end_of_run      = 1'b1;
         rsp_valid_in           = 1'b1;
      end

      if (cmd.clear) begin
         map_in = '0;
         pk_in  = tot_eff;
         gr_in  = ONE_G;
      end

      if (cmd.report_empty) begin
         rsp_in            = '0;
         rsp_in.result_kind = KIND_ENTRY;
         rsp_in.end_of_run = 1'b1;
         rsp_valid_in      = 1'b1;
      end

      if (cmd.scan_start) begin
         n_in   = ONE_P;
         cnt_in = '0;
      end

      if (cmd.scan_step) begin
         if (advance) begin
            n_in = n_up;
         end
         if (emit) begin
            cnt_in                 = cnt_ff + ONE_P;
            rsp_in.result_kind     = KIND_ENTRY;
            rsp_in.accepted        = 1'b0;
            rsp_in.is_final_packet = 1'b0;
            rsp_in.entry_valid     = 1'b1;
            rsp_in.entry_value     = n_ff;
            rsp_in.missing_packets = pk_ff;
            rsp_in.missing_groups  = gr_ff;
            rsp_in.end_of_run      = last;
            rsp_valid_in           = 1'b1;
         end
      end

      if (cmd.recount_start) begin
         n_in  = ONE_P;
         pk_in = '0;
         gr_in = '0;
      end

      if (cmd.recount_step) begin
         n_in = n_up;
         if (miss) begin
            pk_in = pk_ff + ONE_P;
         end
         if (run_start) begin
            gr_in = gr_ff + ONE_G;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tot_ff       <= TOTAL_RESET;
         mode_ff      <= 1'b0;
         map_ff       <= '0;
         pk_ff        <= MAX_P;
         gr_ff        <= ONE_G;
         half_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tot_ff       <= tot_in;
         mode_ff      <= mode_in;
         map_ff       <= map_in;
         pk_ff        <= pk_in;
         gr_ff        <= gr_in;
         half_ff      <= cmd.scan_step ? half_in : half_ff;   // holds across stalls
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   assign status.out_free     = !rsp_valid_ff || rsp_ready;
   assign status.pk_zero      = (pk_ff == '0);
   assign status.scan_last    = last;
   assign status.recount_last = (n_ff == tot_eff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/core/packet_loss_map_reporter.sv
// Packet loss map reporter, top level: ties controller and datapath.
// Depends on plmr_pkg, plmr_ctrl, plmr_dpath.
//
// req channel (valid/ready): one word per request - packet arrival, report
//   request, or clear for a new message. rsp channel (valid/ready): result
//   words from one output register; end_of_run marks each request's last word.
// csr port: total_packets (index 0) and the mode bit (index 1), written while
//   the block is idle.
// Arrival: ack word valid in the cycle after acceptance; loss counts are kept
//   incrementally, so arrivals sustain one per cycle when the receiver keeps up.
// Clear: no result. Report with nothing missing: one word.
// Report: the scan visits packets 1..total one per cycle when the receiver
//   keeps up, at most one word a cycle; mode 1 gives a single-packet run a start
//   and an end word. It stops after the last entry; req_ready is low meanwhile.
// Writing total_packets starts a recount of the bitmap, one packet a cycle
//   up to the effective total, req_ready low; a new total written meanwhile
//   restarts it.
// Reset: bitmap empty, total 64, mode 0, no result pending.
// Receiver stall: the output word holds and the scan pauses; requests wait
//   while the word is pending and not being taken.
module packet_loss_map_reporter #(
   parameter int MAX_PACKETS = plmr_pkg::MAX_PACKETS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  plmr_pkg::req_word_type          req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output plmr_pkg::rsp_word_type          rsp_data,
   input  logic                            csr_we,
   input  logic [plmr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [plmr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import plmr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing: dispatch, report scan, recount
   plmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_data.req_type),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .status    (status),
      .cmd       (cmd)
   );

   // bitmap, counts and the output word
   plmr_dpath #(
      .MAX_PACKETS (MAX_PACKETS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/core/plmr_checker.sv
// Port-level checks for packet_loss_map_reporter, bound to the top level.
// Depends on plmr_pkg.
module plmr_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input plmr_pkg::rsp_word_type rsp_data
);
   import plmr_pkg::*;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // acks carry no entry; entries carry no ack flags
   a_kind_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.result_kind == KIND_ACK &&
          !rsp_data.entry_valid && rsp_data.entry_value == '0 &&
          rsp_data.end_of_run) ||
         (rsp_data.result_kind == KIND_ENTRY &&
          !rsp_data.accepted && !rsp_data.is_final_packet))
      else $error("result fields inconsistent with kind");

   // runs never outnumber missing packets; final implies accepted
   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ({1'b0, rsp_data.missing_groups} <= rsp_data.missing_packets) &&
         (!rsp_data.is_final_packet || rsp_data.accepted))
      else $error("loss counts inconsistent");

endmodule

bind packet_loss_map_reporter plmr_checker u_plmr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
